// ===== sv/udc_pkg.sv =====
// ----------------------------------------------------------------------------
// udc_pkg: shared types and constants for the UART baud divisor calculator
// Request and result payloads, the divider cell state and pipeline depths.
// ----------------------------------------------------------------------------
package udc_pkg;

	localparam int unsigned FRAC_SHIFT = 32;
	localparam int unsigned DIV_STEPS  = 64;
	localparam int unsigned LATENCY    = DIV_STEPS + 2;

	localparam logic [7:0] SAMPLE_RESET = 8'd16;

	typedef struct packed {
		logic [23:0] baud_rate;
		logic [31:0] clock_hz;
	} req_t;

	typedef struct packed {
		logic [15:0] divisor_word;
		logic        ratio_overflow;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] rem;
		logic [31:0] div;
		logic [63:0] dq;
	} cell_t;

endpackage

// ===== sv/udc_div_cell.sv =====
// ----------------------------------------------------------------------------
// udc_div_cell: one restoring division step
// Shifts the next dividend bit into the remainder, subtracts the divisor when
// it fits and shifts the quotient bit into the low end of the dividend word.
// ----------------------------------------------------------------------------
module udc_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  udc_pkg::cell_t prev,
	output udc_pkg::cell_t next
);

	logic [32:0] trial;
	logic [32:0] diff;
	logic        fits;
	logic        valid_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [63:0] dq_q;

	assign trial = {prev.rem, prev.dq[63]};
	assign diff  = trial - {1'b0, prev.div};
	assign fits  = (trial >= {1'b0, prev.div});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		div_q <= prev.div;
		rem_q <= fits ? diff[31:0] : trial[31:0];
		dq_q  <= {prev.dq[62:0], fits};
	end

	assign next = '{valid: valid_q, rem: rem_q, div: div_q, dq: dq_q};

endmodule

// ===== sv/uart_baud_divisor_calc.sv =====
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc: baud register value for an oversampling UART
// Forms ((sample_count * baud_rate) << 32) / clock_hz in a row of restoring
// division cells and answers bits 31..16 of 2^32 minus that ratio.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start, busy          req   (baud_rate, clock_hz)
//  result    done                 rsp   (divisor_word, ratio_overflow)
//  config    cfg_we               cfg_wdata (sample_count)
//
//  A request is taken in every cycle in which start is high; busy stays low.
//  Its result shows on done/rsp after one multiply stage, 64 division cells
//  and one output stage, with one request in flight per stage.
//  Reset clears all valid bits and loads sample_count with 16.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module uart_baud_divisor_calc (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  udc_pkg::req_t req,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	output logic          done,
	output udc_pkg::rsp_t rsp
);

	logic [7:0]     sample_count_q;
	udc_pkg::cell_t chain [0:udc_pkg::DIV_STEPS];
	logic           head_valid_s1;
	logic [31:0]    head_div_s1;
	logic [31:0]    head_prod_s1;
	logic           done_q;
	udc_pkg::rsp_t  rsp_q;
	logic [31:0]    scale_lo;
	logic [63:0]    quot;
	logic           over;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= udc_pkg::SAMPLE_RESET;
		end else if (cfg_we) begin
			sample_count_q <= cfg_wdata;
		end
	end

	// multiply stage: dividend is the product shifted up by the fraction width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_s1 <= 1'b0;
		end else begin
			head_valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		head_div_s1  <= req.clock_hz;
		head_prod_s1 <= {24'd0, sample_count_q} * {8'd0, req.baud_rate};
	end

	assign chain[0] = '{valid: head_valid_s1, rem: 32'd0, div: head_div_s1,
		dq: {head_prod_s1, 32'd0}};

	for (genvar i = 0; i < udc_pkg::DIV_STEPS; i++) begin : g_cell
		udc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.prev   (chain[i]),
			.next   (chain[i+1])
		);
	end

	assign quot     = chain[udc_pkg::DIV_STEPS].dq;
	assign scale_lo = 32'd0 - quot[31:0];
	assign over     = (|quot[63:33]) || (quot[32] && (|quot[31:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[udc_pkg::DIV_STEPS].valid;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q.divisor_word   <= scale_lo[31:16];
		rsp_q.ratio_overflow <= over;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== sv/udc_checker.sv =====
// ----------------------------------------------------------------------------
// udc_checker: port-level checks for the UART baud divisor calculator
// Watches the request and result ports for latency and corner-case values.
// ----------------------------------------------------------------------------
module udc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input udc_pkg::req_t req,
	input logic          done,
	input udc_pkg::rsp_t rsp
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, udc_pkg::LATENCY))
		else $error("result without a request transfer");

	a_zero_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy && (req.clock_hz == 32'd0), udc_pkg::LATENCY))
		|-> (rsp.ratio_overflow && (rsp.divisor_word == 16'd0)))
		else $error("zero clock result wrong");

	a_zero_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && !busy && (req.baud_rate == 24'd0) &&
			(req.clock_hz != 32'd0), udc_pkg::LATENCY))
		|-> (!rsp.ratio_overflow && (rsp.divisor_word == 16'd0)))
		else $error("zero rate result wrong");

endmodule

bind uart_baud_divisor_calc udc_checker u_udc_checker (.*);
